>>> design/assert_macros.svh
// Assertion macros shared by the list table RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UIDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define UIDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/uidl_pkg.sv
// Shared types and constants of the unique id list table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package uidl_pkg;

    // Default sizing of the table.
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ID_BITS_DEF     = 32;

    // Fixed widths of the stream fields.
    localparam int ACT_W      = 2;
    localparam int ID_W       = 32;
    localparam int POS_W      = 6;
    localparam int IN_TDATA_W = 40;

    // Command codes carried in the input tuser.
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

    // Source of the entry_id field in a result.
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ID,
        RES_MEM
    } res_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     start;
        logic     scan;
        logic     shift_start;
        logic     shift;
        logic     read_pos;
        logic     append;
        logic     dec;
        logic     finish;
        logic     res_ok;
        res_src_t res_src;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t in_act;
        action_t act;
        logic    full;
        logic    hit;
        logic    scan_end;
        logic    shift_end;
        logic    pos_ok;
        logic    out_free;
    } status_t;

endpackage

>>> design/unique_id_list_table.sv
// Channel  Signals                       Contents
// s        s_tvalid s_tready s_tdata      song_id [31:0], position [37:32]
//          s_tuser                        action [1:0]
// m        m_tvalid m_tready m_tdata      ok, entry_id, count, is_empty, is_full
//
// Add, remove and find scan one entry a cycle through the single read port.
// A remove that hits then shifts every later entry down one place, one a cycle.
// Read fetches the entry at its position; an add on a full list skips the scan.
// Reset clears the count and the control state; the entries are not cleared.
// A new command is taken while a result waits on m_tready, then holds s_tready low.
//
// Top level of the unique id list table; depends on uidl_pkg, uidl_ctrl and
// uidl_datapath.
`timescale 1ns / 1ps

module unique_id_list_table #(
    parameter int   MAX_ENTRIES = uidl_pkg::MAX_ENTRIES_DEF,
    parameter int   ID_BITS     = uidl_pkg::ID_BITS_DEF,
    localparam int  CntW        = $clog2(MAX_ENTRIES + 1),
    localparam int  OutW        = 1 + uidl_pkg::ID_W + CntW + 2,
    localparam int  OutTdataW   = ((OutW + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uidl_pkg::IN_TDATA_W-1:0] s_tdata,   // song_id, position
    input  logic [uidl_pkg::ACT_W-1:0]      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OutTdataW-1:0]            m_tdata    // ok, entry_id, count, is_empty, is_full
);

    uidl_pkg::cmd_t    cmd;
    uidl_pkg::status_t sts;

    // Sequencer.
    uidl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, scan pointer and result register.
    uidl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> design/uidl_ctrl.sv
// Controller state machine of the unique id list table.
// Depends on uidl_pkg for the state, command and status types.
`timescale 1ns / 1ps

module uidl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  uidl_pkg::status_t sts,
    output uidl_pkg::cmd_t    cmd
);

    uidl_pkg::state_t   state_reg, state_next;
    logic               res_ok_reg, res_ok_next;
    uidl_pkg::res_src_t res_src_reg, res_src_next;

    // State and outcome registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= uidl_pkg::ST_IDLE;
            res_ok_reg  <= 1'b0;
            res_src_reg <= uidl_pkg::RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_ok_reg  <= res_ok_next;
            res_src_reg <= res_src_next;
        end
    end

    // Next state and the outcome that the result beat will report.
    always_comb
    begin
        state_next   = state_reg;
        res_ok_next  = res_ok_reg;
        res_src_next = res_src_reg;
        unique case (state_reg)
            uidl_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (sts.in_act == uidl_pkg::ACT_READ)
                    begin
                        state_next = uidl_pkg::ST_READ;
                    end
                    else if (sts.in_act == uidl_pkg::ACT_ADD && sts.full)
                    begin
                        state_next   = uidl_pkg::ST_DONE;
                        res_ok_next  = 1'b0;
                        res_src_next = uidl_pkg::RES_ZERO;
                    end
                    else
                    begin
                        state_next = uidl_pkg::ST_SCAN;
                    end
                end
            end
            uidl_pkg::ST_SCAN:
            begin
                if (sts.hit)
                begin
                    res_src_next = uidl_pkg::RES_ZERO;
                    unique case (sts.act)
                        uidl_pkg::ACT_REMOVE:
                        begin
                            state_next  = uidl_pkg::ST_SHIFT;
                            res_ok_next = 1'b1;
                        end
                        uidl_pkg::ACT_FIND:
                        begin
                            state_next   = uidl_pkg::ST_DONE;
                            res_ok_next  = 1'b1;
                            res_src_next = uidl_pkg::RES_ID;
                        end
                        default:
                        begin
                            state_next  = uidl_pkg::ST_DONE;
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
                else if (sts.scan_end)
                begin
                    state_next   = uidl_pkg::ST_DONE;
                    res_ok_next  = (sts.act == uidl_pkg::ACT_ADD);
                    res_src_next = uidl_pkg::RES_ZERO;
                end
            end
            uidl_pkg::ST_SHIFT:
            begin
                if (sts.shift_end)
                begin
                    state_next = uidl_pkg::ST_DONE;
                end
            end
            uidl_pkg::ST_READ:
            begin
                state_next   = uidl_pkg::ST_DONE;
                res_ok_next  = sts.pos_ok;
                res_src_next = sts.pos_ok ? uidl_pkg::RES_MEM : uidl_pkg::RES_ZERO;
            end
            uidl_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = uidl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uidl_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.res_ok  = res_ok_reg;
        cmd.res_src = res_src_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            uidl_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            uidl_pkg::ST_SCAN:
            begin
                cmd.scan        = 1'b1;
                cmd.shift_start = sts.hit && (sts.act == uidl_pkg::ACT_REMOVE);
                cmd.append      = !sts.hit && sts.scan_end && (sts.act == uidl_pkg::ACT_ADD);
            end
            uidl_pkg::ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                cmd.dec   = sts.shift_end;
            end
            uidl_pkg::ST_READ:
            begin
                cmd.read_pos = 1'b1;
            end
            uidl_pkg::ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/uidl_datapath.sv
// Datapath of the unique id list table: entry memory, count, scan pointer
// and the result register. Depends on uidl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uidl_datapath #(
    parameter int   MAX_ENTRIES = uidl_pkg::MAX_ENTRIES_DEF,
    parameter int   ID_BITS     = uidl_pkg::ID_BITS_DEF,
    localparam int  AddrW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int  CntW        = $clog2(MAX_ENTRIES + 1),
    localparam int  OutW        = 1 + uidl_pkg::ID_W + CntW + 2,
    localparam int  OutTdataW   = ((OutW + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [uidl_pkg::IN_TDATA_W-1:0] s_tdata,   // song_id, position
    input  logic [uidl_pkg::ACT_W-1:0]      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OutTdataW-1:0]            m_tdata,   // ok, entry_id, count, is_empty, is_full
    input  uidl_pkg::cmd_t                  cmd,
    output uidl_pkg::status_t               sts
);

    localparam int IdW  = uidl_pkg::ID_W;
    localparam int PosW = uidl_pkg::POS_W;
    localparam int CmpW = (CntW > PosW) ? CntW : PosW;

    // Entry storage; contents are undefined until written.
    logic [ID_BITS-1:0] entries_mem [MAX_ENTRIES];

    logic [ID_BITS-1:0]  id_reg;
    uidl_pkg::action_t   act_reg;
    logic [PosW-1:0]     pos_reg;
    logic [CntW-1:0]     idx_reg, idx_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [AddrW-1:0]    rd_idx_reg, rd_idx_next;
    logic [ID_BITS-1:0]  rd_data_reg;
    logic                out_valid_reg, out_valid_next;
    logic                ok_reg;
    logic [IdW-1:0]      entry_reg;
    logic [CntW-1:0]     cnt_out_reg;
    logic                empty_reg;
    logic                full_reg;

    logic                idx_lt;
    logic                hit;
    logic                issue;
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [ID_BITS-1:0]  wr_data;
    logic                full;
    logic [IdW-1:0]      res_entry;

    // Scan and shift pointer compares and the match of the last read.
    assign idx_lt = (idx_reg < count_reg);
    assign hit    = rd_valid_reg && (rd_data_reg == id_reg);
    assign full   = (count_reg == CntW'(MAX_ENTRIES));
    assign issue  = (cmd.scan && !hit && idx_lt) || (cmd.shift && idx_lt);

    // Memory port control: at most one read and one write each cycle.
    always_comb
    begin
        rd_en   = issue || cmd.read_pos;
        rd_addr = cmd.read_pos ? AddrW'(pos_reg) : idx_reg[AddrW-1:0];
        wr_en   = 1'b0;
        wr_addr = count_reg[AddrW-1:0];
        wr_data = id_reg;
        if (cmd.shift && rd_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg - AddrW'(1);
            wr_data = rd_data_reg;
        end
        else if (cmd.append)
        begin
            wr_en = 1'b1;
        end
    end

    // Entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries_mem[rd_addr];
        end
    end

    // Pointer, pending read and count updates.
    always_comb
    begin
        idx_next      = idx_reg;
        rd_valid_next = issue;
        rd_idx_next   = issue ? idx_reg[AddrW-1:0] : rd_idx_reg;
        count_next    = count_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.shift_start)
        begin
            idx_next = CntW'(rd_idx_reg) + CntW'(1);
        end
        else if (issue)
        begin
            idx_next = idx_reg + CntW'(1);
        end
        if (cmd.append)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    // Result field selection.
    always_comb
    begin
        case (cmd.res_src)
            uidl_pkg::RES_ID:  res_entry = IdW'(id_reg);
            uidl_pkg::RES_MEM: res_entry = IdW'(rd_data_reg);
            default:           res_entry = '0;
        endcase
    end

    // Output beat holds until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        if (cmd.start)
        begin
            id_reg  <= ID_BITS'(s_tdata[IdW-1:0]);
            act_reg <= uidl_pkg::action_t'(s_tuser);
            pos_reg <= s_tdata[IdW+PosW-1:IdW];
        end
        if (cmd.finish)
        begin
            ok_reg      <= cmd.res_ok;
            entry_reg   <= res_entry;
            cnt_out_reg <= count_reg;
            empty_reg   <= (count_reg == '0);
            full_reg    <= full;
        end
    end

    // Stream output.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OutTdataW'({full_reg, empty_reg, cnt_out_reg, entry_reg, ok_reg});

    // Status to the controller.
    always_comb
    begin
        sts           = '0;
        sts.in_act    = uidl_pkg::action_t'(s_tuser);
        sts.act       = act_reg;
        sts.full      = full;
        sts.hit       = hit;
        sts.scan_end  = !idx_lt && !rd_valid_reg;
        sts.shift_end = !idx_lt && !rd_valid_reg;
        sts.pos_ok    = (CmpW'(pos_reg) < CmpW'(count_reg));
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // Checks.
    `UIDL_ASSERT(a_count_range, clk, rst_n, count_reg <= CntW'(MAX_ENTRIES), "count above capacity")
    `UIDL_ASSERT(a_finish_free, clk, rst_n, !cmd.finish || !out_valid_reg || m_tready, "result beat overwritten")
    `UIDL_ASSERT(a_shift_write, clk, rst_n, !(cmd.shift && rd_valid_reg) || (CntW'(rd_idx_reg) < count_reg), "shift write beyond count")
    `UIDL_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CntW'(1)) || (count_reg == $past(count_reg) - CntW'(1)), "count moved by more than one")

endmodule

>>> tb/sv/unique_id_list_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the unique id list table: a directed table, then random
// fill, drain, mixed and noise phases, checked beat by beat against an in-bench list model.
// Depends on uidl_pkg and unique_id_list_table.

module unique_id_list_table_tb;

    import uidl_pkg::*;

    localparam int LIST_CAP      = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PAUSE_AT      = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1200000;
    localparam int NUM_DIRECTED  = 22;
    localparam int MAX_REPORTS   = 10;

    // One result beat, packed so that ok sits at bit 0 of m_tdata.
    typedef struct packed {
        logic       is_full;
        logic       is_empty;
        logic [6:0] count;
        logic [31:0] entry_id;
        logic       ok;
    } list_result_t;

    typedef struct packed {
        action_t      act;
        logic [31:0]  id;
        logic [5:0]   pos;
        logic         typed;
        list_result_t res;
    } cmd_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_NOISE
    } phase_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // song_id [31:0], position [37:32], zero pad [39:38]
    logic [ACT_W-1:0]       s_tuser;    // action [1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [47:0]            m_tdata;    // ok, entry_id, count, is_empty, is_full

    unique_id_list_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Model state of the list and the results it still owes.
    logic [31:0]    list_ids [LIST_CAP];
    int             list_count;
    list_result_t   pending_results [$];

    int  mismatch_count;
    int  results_seen;
    int  sent_count;
    int  cycle_count;
    int  n_add_ok;
    int  n_full_reject;
    int  n_dup_reject;
    int  n_remove_ok;
    int  n_lookup_hit;
    int  peak_count;

    // Directed commands; rows with typed set carry their expected beat.
    cmd_row_t directed_cmds [NUM_DIRECTED] = '{
        '{ACT_READ,   32'h0000_0000, 6'd0,  1'b1, '{1'b0, 1'b1, 7'd0, 32'h0, 1'b0}},
        '{ACT_FIND,   32'h0000_0000, 6'd0,  1'b1, '{1'b0, 1'b1, 7'd0, 32'h0, 1'b0}},
        '{ACT_REMOVE, 32'hFFFF_FFFF, 6'd63, 1'b1, '{1'b0, 1'b1, 7'd0, 32'h0, 1'b0}},
        '{ACT_ADD,    32'h0000_0000, 6'd0,  1'b1, '{1'b0, 1'b0, 7'd1, 32'h0, 1'b1}},
        '{ACT_ADD,    32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 1'b0, 7'd2, 32'h0, 1'b1}},
        '{ACT_ADD,    32'h0000_0000, 6'd0,  1'b1, '{1'b0, 1'b0, 7'd2, 32'h0, 1'b0}},
        '{ACT_ADD,    32'h8000_0001, 6'd0,  1'b0, '0},
        '{ACT_ADD,    32'h5A5A_5A5A, 6'd0,  1'b0, '0},
        '{ACT_FIND,   32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 1'b0, 7'd4, 32'hFFFF_FFFF, 1'b1}},
        '{ACT_READ,   32'h0000_0000, 6'd3,  1'b1, '{1'b0, 1'b0, 7'd4, 32'h5A5A_5A5A, 1'b1}},
        '{ACT_READ,   32'hFFFF_FFFF, 6'd4,  1'b1, '{1'b0, 1'b0, 7'd4, 32'h0, 1'b0}},
        '{ACT_READ,   32'h0000_0000, 6'd63, 1'b1, '{1'b0, 1'b0, 7'd4, 32'h0, 1'b0}},
        '{ACT_REMOVE, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
        '{ACT_READ,   32'h0000_0000, 6'd1,  1'b0, '0},
        '{ACT_READ,   32'h0000_0000, 6'd2,  1'b0, '0},
        '{ACT_FIND,   32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 1'b0, 7'd3, 32'h0, 1'b0}},
        '{ACT_REMOVE, 32'h5A5A_5A5A, 6'd0,  1'b0, '0},
        '{ACT_REMOVE, 32'h0000_0000, 6'd0,  1'b0, '0},
        '{ACT_READ,   32'h0000_0000, 6'd0,  1'b0, '0},
        '{ACT_REMOVE, 32'h8000_0001, 6'd42, 1'b1, '{1'b0, 1'b1, 7'd0, 32'h0, 1'b1}},
        '{ACT_ADD,    32'h0000_0001, 6'd21, 1'b0, '0},
        '{ACT_FIND,   32'h0000_0001, 6'd0,  1'b0, '0}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                         pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Applies one command to the model list and returns the beat it should produce.
    function automatic list_result_t list_apply(action_t act, logic [31:0] id, logic [5:0] pos);
        list_result_t r;
        int at;
        int i;
        r  = '0;
        at = -1;
        for (i = 0; i < list_count; i++)
        begin
            if (at < 0 && list_ids[i] == id)
                at = i;
        end
        case (act)
            ACT_ADD:
            begin
                if (list_count >= LIST_CAP)
                    n_full_reject++;
                else if (at >= 0)
                    n_dup_reject++;
                else
                begin
                    list_ids[list_count] = id;
                    list_count++;
                    r.ok = 1'b1;
                    n_add_ok++;
                end
            end
            ACT_REMOVE:
            begin
                if (at >= 0)
                begin
                    // Close the gap by moving every later entry down one place.
                    for (i = at; i + 1 < list_count; i++)
                        list_ids[i] = list_ids[i + 1];
                    list_count--;
                    r.ok = 1'b1;
                    n_remove_ok++;
                end
            end
            ACT_FIND:
            begin
                if (at >= 0)
                begin
                    r.ok       = 1'b1;
                    r.entry_id = list_ids[at];
                    n_lookup_hit++;
                end
            end
            default:
            begin
                if (int'(pos) < list_count)
                begin
                    r.ok       = 1'b1;
                    r.entry_id = list_ids[pos];
                    n_lookup_hit++;
                end
            end
        endcase
        if (list_count > peak_count)
            peak_count = list_count;
        r.count    = 7'(list_count);
        r.is_empty = (list_count == 0);
        r.is_full  = (list_count == LIST_CAP);
        return r;
    endfunction

    // Offers one command beat and holds it until the block takes it.
    task automatic send_cmd(input action_t act, input logic [31:0] id, input logic [5:0] pos,
                            input logic typed, input list_result_t typed_res);
        list_result_t pred;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pos, id};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = list_apply(act, id, pos);
        pending_results.push_back(typed ? typed_res : pred);
        sent_count++;
    endtask

    // Drops s_tvalid for the given gap; a zero gap keeps the stream running.
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Picks an id: either one stored in the list or a fresh value of varied shape.
    function automatic logic [31:0] pick_id(input int present_pct);
        int roll;
        int bit_sel;
        if (list_count > 0 && $urandom_range(0, 99) < present_pct)
            return list_ids[$urandom_range(0, list_count - 1)];
        roll    = $urandom_range(0, 9);
        bit_sel = $urandom_range(0, 31);
        if (roll < 4)
            return $urandom();
        else if (roll < 7)
            return 32'($urandom_range(0, 200));
        else if (roll == 7)
            return (32'h1 << bit_sel);
        else if (roll == 8)
            return ~(32'h1 << bit_sel);
        return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    // Result side: checks each beat and stalls m_tready at random.
    initial
    begin : result_side
        list_result_t got;
        list_result_t want;
        int rx_stall;
        int rx_quiet;
        logic next_ready;
        m_tready <= 1'b0;
        rx_stall = 0;
        rx_quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = list_result_t'(m_tdata[41:0]);
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Unexpected result beat: ok=%0d id=%h count=%0d empty=%0d full=%0d",
                                 got.ok, got.entry_id, got.count, got.is_empty, got.is_full);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok || got.entry_id !== want.entry_id ||
                        got.count !== want.count || got.is_empty !== want.is_empty ||
                        got.is_full !== want.is_full)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("Beat %0d mismatch: expected ok=%0d id=%h count=%0d empty=%0d full=%0d, got ok=%0d id=%h count=%0d empty=%0d full=%0d",
                                     results_seen, want.ok, want.entry_id, want.count,
                                     want.is_empty, want.is_full, got.ok, got.entry_id,
                                     got.count, got.is_empty, got.is_full);
                    end
                end
                // Long hold-off so that a result waits and the input side backs up.
                if (results_seen == 300 || results_seen == 900)
                    rx_stall = HOLD_CYCLES;
            end
            // Alternate stretches with and without stalls.
            if (rx_quiet > 0)
                rx_quiet--;
            else if ($urandom_range(0, 299) == 0)
                rx_quiet = $urandom_range(50, 200);
            if (rx_stall > 0)
            begin
                rx_stall--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (rx_quiet == 0 && $urandom_range(0, 5) == 0)
                    rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
            m_tready <= next_ready;
        end
    end

    // Command side: reset, directed table, random phases, then the final check.
    initial
    begin : command_side
        phase_mode_t mode;
        int phase_idx;
        int phase_len;
        int k;
        int rand_sent;
        int roll;
        int add_pct;
        int rem_pct;
        int find_pct;
        logic quiet;
        action_t act;
        logic [31:0] id;
        logic [5:0] pos;

        mismatch_count = 0;
        results_seen   = 0;
        sent_count     = 0;
        n_add_ok       = 0;
        n_full_reject  = 0;
        n_dup_reject   = 0;
        n_remove_ok    = 0;
        n_lookup_hit   = 0;
        peak_count     = 0;
        list_count     = 0;
        for (k = 0; k < LIST_CAP; k++)
            list_ids[k] = '0;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_ADD;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            send_cmd(directed_cmds[k].act, directed_cmds[k].id, directed_cmds[k].pos,
                     directed_cmds[k].typed, directed_cmds[k].res);
            idle_gap(random_gap());
        end

        // Random phases; the first one fills the list toward capacity.
        rand_sent = 0;
        phase_idx = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            mode      = (phase_idx == 0) ? MODE_FILL : phase_mode_t'($urandom_range(0, 3));
            phase_len = (phase_idx == 0) ? 110 : $urandom_range(20, 120);
            quiet     = ($urandom_range(0, 3) == 0);
            case (mode)
                MODE_FILL:  begin add_pct = 75; rem_pct = 5;  find_pct = 10; end
                MODE_DRAIN: begin add_pct = 10; rem_pct = 60; find_pct = 15; end
                MODE_MIXED: begin add_pct = 30; rem_pct = 25; find_pct = 25; end
                default:    begin add_pct = 25; rem_pct = 25; find_pct = 25; end
            endcase
            for (k = 0; k < phase_len && rand_sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct)
                begin
                    act = ACT_ADD;
                    id  = pick_id((mode == MODE_NOISE) ? 0 : 10);
                end
                else if (roll < add_pct + rem_pct)
                begin
                    act = ACT_REMOVE;
                    id  = pick_id((mode == MODE_NOISE) ? 20 : 85);
                end
                else if (roll < add_pct + rem_pct + find_pct)
                begin
                    act = ACT_FIND;
                    id  = pick_id((mode == MODE_NOISE) ? 20 : 60);
                end
                else
                begin
                    act = ACT_READ;
                    id  = $urandom();
                end
                if (list_count > 0 && mode != MODE_NOISE && $urandom_range(0, 9) < 6)
                    pos = 6'($urandom_range(0, list_count - 1));
                else
                    pos = 6'($urandom_range(0, 63));
                send_cmd(act, id, pos, 1'b0, '0);
                rand_sent++;
                if (rand_sent == PAUSE_AT)
                    wait_drained();
                else
                    idle_gap(quiet ? 0 : random_gap());
            end
            phase_idx++;
        end

        // Let the last results arrive, then watch for stray beats.
        wait_drained();
        repeat (300) @(posedge clk);

        $display("Sent %0d commands in %0d cycles: %0d adds taken, %0d refused on a full list, %0d duplicates refused, %0d removes.",
                 sent_count, cycle_count, n_add_ok, n_full_reject, n_dup_reject, n_remove_ok);
        $display("Lookups and reads that hit: %0d; peak occupancy %0d; result beats %0d, mismatches %0d.",
                 n_lookup_hit, peak_count, results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
